### rtl/sphere_stamp_entry_generator_defines.svh
// Assertion macros of the sphere stamp entry generator checker.
`ifndef SPHERE_STAMP_ENTRY_GENERATOR_DEFINES_SVH
`define SPHERE_STAMP_ENTRY_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define SSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) ante |=> (cons)) \
    else $error(msg);

`endif

### rtl/ssg_pkg.sv
// Shared constants, stage payload types and helper functions of the stamp generator.
`timescale 1ns / 1ps
`default_nettype none
package ssg_pkg;

  localparam int MAX_RADIUS = 32;
  localparam int BALL_IDX_W = $clog2(MAX_RADIUS);
  localparam int RADIUS_W   = 6;
  localparam int STRIDE_W   = 16;
  localparam int COORD_W    = 5;
  localparam int DIM_W      = 6;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int OFS_W      = 22;
  localparam int MASK_W     = 64;
  localparam int MASK_IDX_W = 7;
  localparam int SQ_W       = 13;
  localparam int REM_W      = 14;
  localparam int ODD_W      = 12;
  localparam int NUM_OFS    = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 6'd1;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 16'd64;

  // Offset slots in the packed offset vector, in output order a to h.
  localparam int OFS_A = 0;
  localparam int OFS_B = 1;
  localparam int OFS_C = 2;
  localparam int OFS_D = 3;
  localparam int OFS_E = 4;
  localparam int OFS_F = 5;
  localparam int OFS_G = 6;
  localparam int OFS_H = 7;

  typedef struct packed {
    logic                valid_res;
    logic [RADIUS_W-1:0] r;
    logic [DIM_W-1:0]    k;
    logic [DIM_W-1:0]    i;
    logic [DIM_W-1:0]    pi;
    logic [DIM_W-1:0]    pk;
    logic [DIM_W-1:0]    dk;
    logic [DIM_W-1:0]    di;
  } prep_t;

  typedef struct packed {
    logic                valid_res;
    logic [RADIUS_W-1:0] r;
    logic [DIM_W-1:0]    k;
    logic [DIM_W-1:0]    i;
    logic [DIM_W-1:0]    pi;
    logic [DIM_W-1:0]    pk;
    logic [OFS_W-1:0]    prod_k;
    logic [OFS_W-1:0]    prod_i;
    logic [OFS_W-1:0]    prod_pi;
    logic [OFS_W-1:0]    prod_pk;
    logic [SQ_W-1:0]     base;
    logic [SQ_W-1:0]     lim;
  } mult_t;

  typedef struct packed {
    logic                            valid_res;
    logic [RADIUS_W-1:0]             r;
    logic [NUM_OFS-1:0][OFS_W-1:0]   ofs;
    logic [MAX_RADIUS-1:0]           in_ball;
  } cmp_t;

  typedef struct packed {
    logic                            valid_res;
    logic [NUM_OFS-1:0][OFS_W-1:0]   ofs;
    logic [MASK_W-1:0]               depth_mask;
  } res_t;

  // Square of the odd distance 2j+1 in half-voxel units.
  function automatic logic [ODD_W-1:0] odd_sq(input int j);
    int m;
    m = 2 * j + 1;
    return ODD_W'(m * m);
  endfunction

endpackage
`default_nettype wire

### rtl/ssg_ifs.sv
// Request and result channel interfaces of the stamp generator.
`timescale 1ns / 1ps
`default_nettype none
interface ssg_req_if;
  import ssg_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] layer;
  logic [COORD_W-1:0] position;

  modport source (output valid, output layer, output position, input ready);
  modport sink (input valid, input layer, input position, output ready);
endinterface

interface ssg_res_if;
  import ssg_pkg::*;

  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [OFS_W-1:0]  offset_a;
  logic [OFS_W-1:0]  offset_b;
  logic [OFS_W-1:0]  offset_c;
  logic [OFS_W-1:0]  offset_d;
  logic [OFS_W-1:0]  offset_e;
  logic [OFS_W-1:0]  offset_f;
  logic [OFS_W-1:0]  offset_g;
  logic [OFS_W-1:0]  offset_h;
  logic [MASK_W-1:0] depth_mask;

  modport source (
    output valid, output valid_res,
    output offset_a, output offset_b, output offset_c, output offset_d,
    output offset_e, output offset_f, output offset_g, output offset_h,
    output depth_mask, input ready
  );
  modport sink (
    input valid, input valid_res,
    input offset_a, input offset_b, input offset_c, input offset_d,
    input offset_e, input offset_f, input offset_g, input offset_h,
    input depth_mask, output ready
  );
endinterface
`default_nettype wire

### rtl/ssg_prep_stage.sv
// First pipeline stage: radius saturation, range check and mirrored coordinates.
`timescale 1ns / 1ps
`default_nettype none
module ssg_prep_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  wire logic [ssg_pkg::COORD_W-1:0]  layer_i,
  input  wire logic [ssg_pkg::COORD_W-1:0]  position_i,
  input  wire logic [ssg_pkg::RADIUS_W-1:0] radius_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output ssg_pkg::prep_t                    data_o
);
  import ssg_pkg::*;

  logic                v_q;
  prep_t               data_d;
  prep_t               data_q;
  logic [RADIUS_W-1:0] r_sat;
  logic [DIM_W:0]      two_r;
  logic [DIM_W-1:0]    p;
  logic [DIM_W-1:0]    k;
  logic [DIM_W-1:0]    i;

  always_comb begin
    r_sat = (radius_i > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_i;
    two_r = {r_sat, 1'b0};
    // For a radius of 32 the low bits of 2r wrap to zero and p still comes out as 63.
    p     = two_r[DIM_W-1:0] - DIM_W'(1);
    k     = {1'b0, layer_i};
    i     = {1'b0, position_i};

    data_d.valid_res = (r_sat != '0) && (k <= i) && (i < DIM_W'(r_sat));
    data_d.r         = r_sat;
    data_d.k         = k;
    data_d.i         = i;
    data_d.pi        = p - i;
    data_d.pk        = p - k;
    // Both distances are positive for any valid request since k and i lie below r.
    data_d.dk        = p - {k[DIM_W-2:0], 1'b0};
    data_d.di        = p - {i[DIM_W-2:0], 1'b0};
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

### rtl/ssg_mult_stage.sv
// Second pipeline stage: stride products and squared distances.
`timescale 1ns / 1ps
`default_nettype none
module ssg_mult_stage (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         valid_i,
  output logic                              ready_o,
  input  ssg_pkg::prep_t                    data_i,
  input  wire logic [ssg_pkg::STRIDE_W-1:0] stride_i,
  output logic                              valid_o,
  input  wire logic                         ready_i,
  output ssg_pkg::mult_t                    data_o
);
  import ssg_pkg::*;

  logic           v_q;
  mult_t          data_d;
  mult_t          data_q;
  logic [DIM_W:0] two_r;

  always_comb begin
    two_r = {data_i.r, 1'b0};

    data_d.valid_res = data_i.valid_res;
    data_d.r         = data_i.r;
    data_d.k         = data_i.k;
    data_d.i         = data_i.i;
    data_d.pi        = data_i.pi;
    data_d.pk        = data_i.pk;
    data_d.prod_k    = OFS_W'(data_i.k) * OFS_W'(stride_i);
    data_d.prod_i    = OFS_W'(data_i.i) * OFS_W'(stride_i);
    data_d.prod_pi   = OFS_W'(data_i.pi) * OFS_W'(stride_i);
    data_d.prod_pk   = OFS_W'(data_i.pk) * OFS_W'(stride_i);
    data_d.base      = SQ_W'(data_i.dk) * SQ_W'(data_i.dk)
                     + SQ_W'(data_i.di) * SQ_W'(data_i.di);
    data_d.lim       = SQ_W'(two_r) * SQ_W'(two_r);
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

### rtl/ssg_cmp_stage.sv
// Third pipeline stage: offset sums and the per-distance inside test.
`timescale 1ns / 1ps
`default_nettype none
module ssg_cmp_stage (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    valid_i,
  output logic         ready_o,
  input  ssg_pkg::mult_t data_i,
  output logic         valid_o,
  input  wire logic    ready_i,
  output ssg_pkg::cmp_t  data_o
);
  import ssg_pkg::*;

  logic                     v_q;
  cmp_t                     data_d;
  cmp_t                     data_q;
  logic signed [REM_W-1:0]  rem;

  always_comb begin
    // Room left for the depth term: 4r^2 minus the layer and position terms.
    rem = $signed({1'b0, data_i.lim}) - $signed({1'b0, data_i.base});

    data_d.valid_res  = data_i.valid_res;
    data_d.r          = data_i.r;
    data_d.ofs[OFS_A] = data_i.prod_k  + OFS_W'(data_i.i);
    data_d.ofs[OFS_B] = data_i.prod_k  + OFS_W'(data_i.pi);
    data_d.ofs[OFS_C] = data_i.prod_i  + OFS_W'(data_i.k);
    data_d.ofs[OFS_D] = data_i.prod_i  + OFS_W'(data_i.pk);
    data_d.ofs[OFS_E] = data_i.prod_pi + OFS_W'(data_i.k);
    data_d.ofs[OFS_F] = data_i.prod_pi + OFS_W'(data_i.pk);
    data_d.ofs[OFS_G] = data_i.prod_pk + OFS_W'(data_i.i);
    data_d.ofs[OFS_H] = data_i.prod_pk + OFS_W'(data_i.pi);

    // Bit j tells whether a voxel 2j+1 half cells from the depth center is inside.
    for (int j = 0; j < MAX_RADIUS; j++) begin
      data_d.in_ball[j] = rem > $signed({{(REM_W - ODD_W){1'b0}}, odd_sq(j)});
    end
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

### rtl/ssg_out_stage.sv
// Output stage: mirrored depth mask expansion and zeroing of invalid requests.
`timescale 1ns / 1ps
`default_nettype none
module ssg_out_stage (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  ssg_pkg::cmp_t data_i,
  output logic          valid_o,
  input  wire logic     ready_i,
  output ssg_pkg::res_t data_o
);
  import ssg_pkg::*;

  logic                  v_q;
  res_t                  data_d;
  res_t                  data_q;
  logic [MASK_IDX_W-1:0] half_idx;
  logic [MASK_IDX_W-1:0] r_ext;

  always_comb begin
    r_ext            = MASK_IDX_W'(data_i.r);
    half_idx         = '0;
    data_d.valid_res = data_i.valid_res;
    data_d.ofs       = data_i.valid_res ? data_i.ofs : '0;
    // Mask bit b sits at half-distance index r-1-b below the center and b-r above it.
    for (int b = 0; b < MASK_W; b++) begin
      if (MASK_IDX_W'(b) < r_ext) begin
        half_idx = r_ext - MASK_IDX_W'(b) - MASK_IDX_W'(1);
      end else begin
        half_idx = MASK_IDX_W'(b) - r_ext;
      end
      data_d.depth_mask[b] = data_i.valid_res
                           && (half_idx < MASK_IDX_W'(MAX_RADIUS))
                           && data_i.in_ball[half_idx[BALL_IDX_W-1:0]];
    end
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = v_q;
  assign data_o  = data_q;
endmodule
`default_nettype wire

### rtl/sphere_stamp_entry_generator.sv
// Pipeline: four register stages (prep, mult, cmp, out); a request accepted by the prep
// stage moves through the mult, cmp and out registers to the output channel.
// Throughput: one request per clock cycle while the output side does not stall.
// Each stage holds its item only while the next one is full and stalled.
// Reset clears all pipeline valid bits and sets radius to 1 and row stride to 64.
`timescale 1ns / 1ps
`default_nettype none
module sphere_stamp_entry_generator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ssg_pkg::CFG_W-1:0]     cfg_data_i,
  ssg_req_if.sink                            req_i,
  ssg_res_if.source                          res_o
);
  import ssg_pkg::*;

  logic [RADIUS_W-1:0] radius_q;
  logic [STRIDE_W-1:0] stride_q;

  logic  prep_valid;
  logic  prep_ready;
  prep_t prep_data;
  logic  mult_valid;
  logic  mult_ready;
  mult_t mult_data;
  logic  cmp_valid;
  logic  cmp_ready;
  cmp_t  cmp_data;
  res_t  res_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      stride_q <= STRIDE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_STRIDE: stride_q <= cfg_data_i[STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssg_prep_stage u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (req_i.valid),
    .ready_o    (req_i.ready),
    .layer_i    (req_i.layer),
    .position_i (req_i.position),
    .radius_i   (radius_q),
    .valid_o    (prep_valid),
    .ready_i    (prep_ready),
    .data_o     (prep_data)
  );

  ssg_mult_stage u_mult (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (prep_valid),
    .ready_o  (prep_ready),
    .data_i   (prep_data),
    .stride_i (stride_q),
    .valid_o  (mult_valid),
    .ready_i  (mult_ready),
    .data_o   (mult_data)
  );

  ssg_cmp_stage u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mult_valid),
    .ready_o (mult_ready),
    .data_i  (mult_data),
    .valid_o (cmp_valid),
    .ready_i (cmp_ready),
    .data_o  (cmp_data)
  );

  ssg_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmp_valid),
    .ready_o (cmp_ready),
    .data_i  (cmp_data),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res_data)
  );

  assign res_o.valid_res  = res_data.valid_res;
  assign res_o.offset_a   = res_data.ofs[OFS_A];
  assign res_o.offset_b   = res_data.ofs[OFS_B];
  assign res_o.offset_c   = res_data.ofs[OFS_C];
  assign res_o.offset_d   = res_data.ofs[OFS_D];
  assign res_o.offset_e   = res_data.ofs[OFS_E];
  assign res_o.offset_f   = res_data.ofs[OFS_F];
  assign res_o.offset_g   = res_data.ofs[OFS_G];
  assign res_o.offset_h   = res_data.ofs[OFS_H];
  assign res_o.depth_mask = res_data.depth_mask;
endmodule
`default_nettype wire

### rtl/ssg_checker.sv
// Port-level checker of the stamp generator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sphere_stamp_entry_generator_defines.svh"
module ssg_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          req_valid_i,
  input wire logic                          req_ready_i,
  input wire logic                          res_valid_i,
  input wire logic                          res_ready_i,
  input wire logic                          valid_res_i,
  input wire logic [ssg_pkg::OFS_W-1:0]     offset_a_i,
  input wire logic [ssg_pkg::OFS_W-1:0]     offset_b_i,
  input wire logic [ssg_pkg::OFS_W-1:0]     offset_c_i,
  input wire logic [ssg_pkg::OFS_W-1:0]     offset_d_i,
  input wire logic [ssg_pkg::OFS_W-1:0]     offset_e_i,
  input wire logic [ssg_pkg::OFS_W-1:0]     offset_f_i,
  input wire logic [ssg_pkg::OFS_W-1:0]     offset_g_i,
  input wire logic [ssg_pkg::OFS_W-1:0]     offset_h_i,
  input wire logic [ssg_pkg::MASK_W-1:0]    depth_mask_i
);
  import ssg_pkg::*;

  // A position outside the stamp must come out with every field cleared.
  `SSG_ASSERT_NOW(a_invalid_zero, res_valid_i && !valid_res_i, (offset_a_i == '0) && (offset_b_i == '0) && (offset_c_i == '0) && (offset_d_i == '0) && (offset_e_i == '0) && (offset_f_i == '0) && (offset_g_i == '0) && (offset_h_i == '0) && (depth_mask_i == '0), "result for an invalid position has nonzero fields")

  // With the output side taking results, a request reaches the output after the pipeline depth.
  `SSG_ASSERT_NEXT(a_latency, req_valid_i && req_ready_i ##1 res_ready_i ##1 res_ready_i ##1 res_ready_i, res_valid_i, "request did not reach the output through a free-flowing pipeline")

  `SSG_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i, "result withdrawn while stalled")

  `SSG_ASSERT_NEXT(a_res_stable, res_valid_i && !res_ready_i, $stable(depth_mask_i) && $stable(offset_a_i) && $stable(valid_res_i), "stalled result changed")
endmodule

bind sphere_stamp_entry_generator ssg_checker u_ssg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .valid_res_i  (res_o.valid_res),
  .offset_a_i   (res_o.offset_a),
  .offset_b_i   (res_o.offset_b),
  .offset_c_i   (res_o.offset_c),
  .offset_d_i   (res_o.offset_d),
  .offset_e_i   (res_o.offset_e),
  .offset_f_i   (res_o.offset_f),
  .offset_g_i   (res_o.offset_g),
  .offset_h_i   (res_o.offset_h),
  .depth_mask_i (res_o.depth_mask)
);
`default_nettype wire
